/* design/yuy2p_pkg.sv */
package yuy2p_pkg;

	// Default sizes of the line buffer and of the frame height
	localparam int MAX_LINE_PAIRS_DEF = 1024;
	localparam int MAX_ROW_PAIRS_DEF  = 1024;

	localparam int SAMPLE_W   = 8;
	localparam int CHROMA_W   = 2 * SAMPLE_W;  // V in the upper byte, U in the lower
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Register reset values
	localparam int LINE_PAIRS_RST    = 360;
	localparam int ROW_PAIRS_RST     = 240;
	localparam bit CHROMA_FORMAT_RST = 1'b0;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LINE_PAIRS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_PAIRS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_FORMAT = 2'd2;

	// Chroma format codes
	localparam logic FMT_420 = 1'b0;
	localparam logic FMT_422 = 1'b1;

	typedef struct packed {
		logic [SAMPLE_W-1:0] luma_first;
		logic [SAMPLE_W-1:0] luma_second;
		logic [SAMPLE_W-1:0] chroma_u;
		logic [SAMPLE_W-1:0] chroma_v;
	} pix_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] out_luma_first;
		logic [SAMPLE_W-1:0] out_chroma_u;
		logic [SAMPLE_W-1:0] out_luma_second;
		logic [SAMPLE_W-1:0] out_chroma_v;
		logic                row_end;
		logic                frame_end;
	} pix_out_t;

	// Where the output chroma comes from
	typedef enum logic [1:0] {
		CH_PASS,  // chroma delivered with the item
		CH_BUF,   // stored line
		CH_AVG    // mean of stored line and delivered chroma
	} chroma_sel_t;

	typedef struct packed {
		chroma_sel_t sel;
		logic        wr_en;
		logic        row_end;
		logic        frame_end;
	} item_ctl_t;

endpackage

/* design/yuy2p_ram.sv */
module yuy2p_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* design/yuy2p_seq.sv */
module yuy2p_seq #(
	parameter int MAX_LINE_PAIRS = yuy2p_pkg::MAX_LINE_PAIRS_DEF,
	parameter int MAX_ROW_PAIRS  = yuy2p_pkg::MAX_ROW_PAIRS_DEF,
	localparam int COL_W = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  accept,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [yuy2p_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [yuy2p_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic [COL_W-1:0]                      col,
	output yuy2p_pkg::item_ctl_t                  ctl
);

	localparam int LP_W = $clog2(MAX_LINE_PAIRS + 1);
	localparam int RP_W = $clog2(MAX_ROW_PAIRS + 1);
	localparam int ROW_W = $clog2(2 * MAX_ROW_PAIRS);
	localparam int LP_RST = (yuy2p_pkg::LINE_PAIRS_RST > MAX_LINE_PAIRS) ?
		MAX_LINE_PAIRS : yuy2p_pkg::LINE_PAIRS_RST;
	localparam int RP_RST = (yuy2p_pkg::ROW_PAIRS_RST > MAX_ROW_PAIRS) ?
		MAX_ROW_PAIRS : yuy2p_pkg::ROW_PAIRS_RST;

	logic [LP_W-1:0]  lp_q, lp_new;
	logic [RP_W-1:0]  rp_q, rp_new;
	logic             fmt_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [RP_W:0]    rows;
	logic             last_pair;

	assign cfg_ready = 1'b1;

	// sizes are kept already clamped to their legal range
	always_comb begin
		if (cfg_data == '0) begin
			lp_new = LP_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_LINE_PAIRS)) begin
			lp_new = LP_W'(MAX_LINE_PAIRS);
		end else begin
			lp_new = LP_W'(cfg_data);
		end
		if (cfg_data == '0) begin
			rp_new = RP_W'(1);
		end else if (32'(cfg_data) > 32'(MAX_ROW_PAIRS)) begin
			rp_new = RP_W'(MAX_ROW_PAIRS);
		end else begin
			rp_new = RP_W'(cfg_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_q  <= LP_W'(LP_RST);
			rp_q  <= RP_W'(RP_RST);
			fmt_q <= yuy2p_pkg::CHROMA_FORMAT_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				yuy2p_pkg::CFG_LINE_PAIRS:    lp_q  <= lp_new;
				yuy2p_pkg::CFG_ROW_PAIRS:     rp_q  <= rp_new;
				yuy2p_pkg::CFG_CHROMA_FORMAT: fmt_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign rows      = {rp_q, 1'b0};
	assign last_pair = (32'(row_q) + 32'd2) >= 32'(rows);

	always_comb begin
		ctl.row_end   = (32'(col_q) + 32'd1) >= 32'(lp_q);
		ctl.frame_end = ctl.row_end && ((32'(row_q) + 32'd1) >= 32'(rows));
		if (fmt_q == yuy2p_pkg::FMT_422) begin
			ctl.sel   = yuy2p_pkg::CH_PASS;
			ctl.wr_en = 1'b0;
		end else if (row_q == '0) begin
			ctl.sel   = yuy2p_pkg::CH_PASS;
			ctl.wr_en = 1'b1;
		end else if (!row_q[0] || last_pair) begin
			ctl.sel   = yuy2p_pkg::CH_BUF;
			ctl.wr_en = 1'b0;
		end else begin
			ctl.sel   = yuy2p_pkg::CH_AVG;
			ctl.wr_en = 1'b1;
		end
	end

	assign col = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (ctl.row_end) begin
				col_q <= '0;
				row_q <= ctl.frame_end ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(col_q) < 32'(MAX_LINE_PAIRS))
		else $error("column counter past line buffer");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(row_q) < 32'(2 * MAX_ROW_PAIRS))
		else $error("row counter past maximum height");
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl.frame_end |=> col_q == '0 && row_q == '0)
		else $error("counters did not wrap at frame end");
`endif

endmodule

/* design/yuy2p_pack.sv */
module yuy2p_pack #(
	parameter int MAX_LINE_PAIRS = yuy2p_pkg::MAX_LINE_PAIRS_DEF,
	localparam int COL_W = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  yuy2p_pkg::pix_in_t   in_data,
	input  logic [COL_W-1:0]     col,
	input  yuy2p_pkg::item_ctl_t ctl,
	output logic                 out_valid,
	input  logic                 out_ready,
	output yuy2p_pkg::pix_out_t  out_data
);

	localparam int SW = yuy2p_pkg::SAMPLE_W;
	localparam int CW = yuy2p_pkg::CHROMA_W;

	logic                 accept, adv_s1;
	logic                 valid_s1, valid_s2;
	yuy2p_pkg::pix_in_t   pix_s1;
	logic [COL_W-1:0]     col_s1;
	yuy2p_pkg::item_ctl_t ctl_s1;
	logic                 hit_s1;
	logic [CW-1:0]        fwd_s1;
	logic [CW-1:0]        rdata, stored, wdata;
	logic                 wr_en;
	logic [SW:0]          sum_u, sum_v;
	logic [SW-1:0]        ou, ov;
	yuy2p_pkg::pix_out_t  out_s2;

	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign accept   = in_valid && in_ready;

	// line buffer is written when the item leaves stage 1
	assign wdata = {pix_s1.chroma_v, pix_s1.chroma_u};
	assign wr_en = adv_s1 && ctl_s1.wr_en;

	yuy2p_ram #(
		.WIDTH (CW),
		.DEPTH (MAX_LINE_PAIRS)
	) u_line (
		.clk   (clk),
		.we    (wr_en),
		.waddr (col_s1),
		.wdata (wdata),
		.re    (accept),
		.raddr (col),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				// same-column write in flight: read misses it, bypass
				hit_s1   <= wr_en && (col_s1 == col);
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
			end else if (out_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pix_s1 <= in_data;
			col_s1 <= col;
			ctl_s1 <= ctl;
			fwd_s1 <= wdata;
		end
		if (adv_s1) begin
			out_s2 <= {pix_s1.luma_first, ou, pix_s1.luma_second, ov,
				ctl_s1.row_end, ctl_s1.frame_end};
		end
	end

	assign stored = hit_s1 ? fwd_s1 : rdata;
	assign sum_u  = {1'b0, stored[SW-1:0]} + {1'b0, pix_s1.chroma_u};
	assign sum_v  = {1'b0, stored[CW-1:SW]} + {1'b0, pix_s1.chroma_v};

	always_comb begin
		case (ctl_s1.sel)
			yuy2p_pkg::CH_BUF: begin
				ou = stored[SW-1:0];
				ov = stored[CW-1:SW];
			end
			yuy2p_pkg::CH_AVG: begin
				ou = sum_u[SW:1];
				ov = sum_v[SW:1];
			end
			default: begin
				ou = pix_s1.chroma_u;
				ov = pix_s1.chroma_v;
			end
		endcase
	end

	assign out_valid = valid_s2;
	assign out_data  = out_s2;

`ifndef SYNTHESIS
	a_frame_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.frame_end |-> out_data.row_end)
		else $error("frame end without row end");
	a_pass: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && ctl_s1.sel == yuy2p_pkg::CH_PASS |=>
		out_s2.out_chroma_u == $past(pix_s1.chroma_u) &&
		out_s2.out_chroma_v == $past(pix_s1.chroma_v))
		else $error("passthrough chroma altered");
	a_buf_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ctl_s1.sel == yuy2p_pkg::CH_PASS || ctl_s1.sel == yuy2p_pkg::CH_AVG)
		else $error("line buffer written on a buffered row");
`endif

endmodule

/* design/planar_yuv_to_yuy2_packer_core.sv */
// A result passes the input stage and then the result reg before it is offered; either can stall.
// Throughput: one pixel pair per cycle while out_ready is high; the line buffer RAM has one write and one
//   registered read port, and a same-column write in flight is bypassed.
// Reset (arst_n low, async): pipeline empty, row/column counters zero, registers back to
//   line_pairs 360, row_pairs 240, 4:2:0. The chroma line RAM is not cleared.
module planar_yuv_to_yuy2_packer_core #(
	parameter int MAX_LINE_PAIRS = yuy2p_pkg::MAX_LINE_PAIRS_DEF,
	parameter int MAX_ROW_PAIRS  = yuy2p_pkg::MAX_ROW_PAIRS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel pair in
	input  logic                             in_valid,
	output logic                             in_ready,
	input  yuy2p_pkg::pix_in_t               in_data,
	// YUY2 group out
	output logic                             out_valid,
	input  logic                             out_ready,
	output yuy2p_pkg::pix_out_t              out_data,
	// register writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [yuy2p_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [yuy2p_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int COL_W = (MAX_LINE_PAIRS > 1) ? $clog2(MAX_LINE_PAIRS) : 1;

	logic [COL_W-1:0]     col;
	yuy2p_pkg::item_ctl_t ctl;
	logic                 in_accept;

	// A transaction on the input advances the raster counters.
	assign in_accept = in_valid && in_ready;

	// Sequencer: size/format registers and raster position. It decides per item
	// whether chroma passes through, comes from the stored line, or is averaged,
	// and whether the delivered chroma is written back to the line.
	yuy2p_seq #(
		.MAX_LINE_PAIRS (MAX_LINE_PAIRS),
		.MAX_ROW_PAIRS  (MAX_ROW_PAIRS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.col       (col),
		.ctl       (ctl)
	);

	// Datapath: input stage plus line RAM read, chroma select/average, result
	// register that decouples the output handshake from the input.
	yuy2p_pack #(
		.MAX_LINE_PAIRS (MAX_LINE_PAIRS)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.col       (col),
		.ctl       (ctl),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
